@@ hdl/msbp_pkg.sv @@
`default_nettype none

package msbp_pkg;

    localparam int BYTE_W = 8;

    // data bytes still expected after a status byte
    localparam logic [1:0] EXP_SINGLE = 2'd0;
    localparam logic [1:0] EXP_ONE    = 2'd1;
    localparam logic [1:0] EXP_TWO    = 2'd2;
    localparam logic [1:0] EXP_ABSORB = 2'd3;

    // data bytes collected so far
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_IDLE = 2'd3;

    localparam int         STATUS_BIT = 7;
    localparam logic [2:0] SYS_GROUP  = 3'h7;

    typedef logic [BYTE_W-1:0] midi_byte_t;

    typedef struct packed {
        midi_byte_t data2;
        midi_byte_t data1;
        midi_byte_t status;
    } midi_msg_t;

    typedef struct packed {
        midi_msg_t  held;
        logic [1:0] collected;
        logic [1:0] expected;
    } parse_state_t;

    function automatic logic [1:0] chan_expect(input logic [2:0] group);
        logic [1:0] exp;
        unique case (group)
            3'h4, 3'h5: exp = EXP_ONE;
            3'h7:       exp = EXP_SINGLE;
            default:    exp = EXP_TWO;
        endcase
        return exp;
    endfunction

    function automatic logic [1:0] sys_expect(input logic [3:0] code);
        logic [1:0] exp;
        unique case (code)
            4'h0:       exp = EXP_ABSORB;
            4'h1, 4'h3: exp = EXP_ONE;
            4'h2, 4'hF: exp = EXP_TWO;
            default:    exp = EXP_SINGLE;
        endcase
        return exp;
    endfunction

endpackage

`default_nettype wire

@@ hdl/msbp_decode.sv @@
`default_nettype none

module msbp_decode (
    input  msbp_pkg::midi_byte_t   rx_byte,
    input  msbp_pkg::parse_state_t cur,
    output msbp_pkg::parse_state_t nxt,
    output logic                   emit,
    output msbp_pkg::midi_msg_t    msg
);
    import msbp_pkg::*;

    logic [2:0] group;
    logic [1:0] exp;

    assign group = rx_byte[6:4];
    assign exp   = (group == SYS_GROUP) ? sys_expect(rx_byte[3:0]) : chan_expect(group);

    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        if (rx_byte[STATUS_BIT]) begin
            nxt.held.status = rx_byte;
            if (group == SYS_GROUP && exp == EXP_SINGLE) begin
                nxt.held.data1 = '0;
                nxt.held.data2 = '0;
                emit           = 1'b1;
            end else begin
                nxt.expected  = exp;
                nxt.collected = CNT_NONE;
            end
        end else begin
            unique case (cur.collected)
                CNT_NONE: begin
                    nxt.held.data1 = rx_byte;
                    if (cur.expected == EXP_ONE) begin
                        nxt.held.data2 = '0;
                        emit           = 1'b1;
                    end else begin
                        nxt.collected = CNT_ONE;
                    end
                end
                CNT_ONE: begin
                    nxt.held.data2 = rx_byte;
                    if (cur.expected == EXP_TWO) begin
                        emit          = 1'b1;
                        nxt.collected = CNT_NONE;
                    end
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end
    end

    assign msg = nxt.held;

endmodule

`default_nettype wire

@@ hdl/msbp_out_stage.sv @@
`default_nettype none

module msbp_out_stage (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  msbp_pkg::midi_msg_t  load_msg,
    output logic                 free,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [23:0]          m_tdata    // msg_status, msg_data1, msg_data2
);
    import msbp_pkg::*;

    logic      valid_reg, valid_next;
    midi_msg_t msg_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            msg_reg <= load_msg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = msg_reg;

endmodule

`default_nettype wire

@@ hdl/midi_serial_byte_parser_unit.sv @@
`default_nettype none

// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[7:0]  rx_byte
// m_      | out | m_tvalid/m_tready  | m_tdata[23:0] status, data1, data2
//
// One byte a cycle when no stalled result holds an emitting byte: input register,
// one decode step, result register; messages are shown from the result register.
// Synchronous active-low reset clears the valid flags and enters idle, absorb mode.
// A stalled result holds the decode step; bytes that emit nothing still advance.

module midi_serial_byte_parser_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // rx_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata     // msg_status, msg_data1, msg_data2
);
    import msbp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    midi_byte_t   in_byte_reg;
    logic [1:0]   collected_reg;
    logic [1:0]   expected_reg;
    midi_msg_t    held_reg;
    parse_state_t cur, nxt;
    logic         emit, consume, out_free;
    midi_msg_t    msg;

    assign cur = {held_reg, collected_reg, expected_reg};

    msbp_decode u_decode (
        .rx_byte (in_byte_reg),
        .cur     (cur),
        .nxt     (nxt),
        .emit    (emit),
        .msg     (msg)
    );

    assign consume       = in_valid_reg && (!emit || out_free);
    assign s_tready      = !in_valid_reg || consume;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            collected_reg <= CNT_IDLE;
            expected_reg  <= EXP_ABSORB;
        end else begin
            in_valid_reg <= in_valid_next;
            if (consume) begin
                collected_reg <= nxt.collected;
                expected_reg  <= nxt.expected;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (consume) begin
            held_reg <= nxt.held;
        end
    end

    msbp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && emit),
        .load_msg (msg),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_cnt_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        collected_reg != 2'd2)
        else $error("collected count reached an unused code");

    a_one_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        collected_reg == CNT_ONE |-> expected_reg != EXP_ONE)
        else $error("one data byte held while only one expected");

    a_emit_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && emit |=> m_tvalid)
        else $error("emitted message not shown");

    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled byte lost");
`endif

endmodule

`default_nettype wire
